[rtl/core/clipmix_pkg.sv]
package clipmix_pkg;

   localparam int VOICE_COUNT = 4;
   localparam int SAMPLE_ADDR_BITS = 16;
   localparam int CLIP_COUNT = 256;

   localparam int STORE_SIZE = 1 << SAMPLE_ADDR_BITS;
   localparam int VOICE_IDX_BITS = $clog2(VOICE_COUNT);
   localparam int CLIP_IDX_BITS = $clog2(CLIP_COUNT);

   localparam int CODE_BITS = 8;
   localparam int START_BITS = 16;
   localparam int LENGTH_BITS = 17;
   localparam int SAMPLE_BITS = 8;
   localparam int ACC_BITS = SAMPLE_BITS + VOICE_IDX_BITS;
   localparam int ADDR_SUM_BITS =
      (SAMPLE_ADDR_BITS > LENGTH_BITS + 1) ? SAMPLE_ADDR_BITS : LENGTH_BITS + 1;

   localparam logic [CODE_BITS-1:0] NO_CODE = 8'hff;
   localparam int MIX_MAX = 120;
   localparam int MIX_MIN = -120;
   localparam logic signed [ACC_BITS-1:0] MIX_MAX_ACC = ACC_BITS'(MIX_MAX);
   localparam logic signed [ACC_BITS-1:0] MIX_MIN_ACC = ACC_BITS'(MIX_MIN);

   typedef enum logic [1:0] {
      REQ_PLAY   = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_SAMPLE = 2'd2,
      REQ_CLIP   = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic                   loop;
      logic [LENGTH_BITS-1:0] length;
      logic [START_BITS-1:0]  start;
   } clip_entry_type;

endpackage

[rtl/core/clipmix_sample_ram.sv]
module clipmix_sample_ram (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [clipmix_pkg::SAMPLE_ADDR_BITS-1:0]     wr_addr,
   input  logic signed [clipmix_pkg::SAMPLE_BITS-1:0]   wr_data,
   input  logic                                         rd_en,
   input  logic [clipmix_pkg::SAMPLE_ADDR_BITS-1:0]     rd_addr,
   output logic signed [clipmix_pkg::SAMPLE_BITS-1:0]   rd_data
);

   logic signed [clipmix_pkg::SAMPLE_BITS-1:0] sample_mem [clipmix_pkg::STORE_SIZE];
   logic signed [clipmix_pkg::SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= sample_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/clipmix_clip_table.sv]
module clipmix_clip_table (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    wr_en,
   input  logic [clipmix_pkg::CLIP_IDX_BITS-1:0]   wr_idx,
   input  clipmix_pkg::clip_entry_type             wr_entry,
   input  logic                                    rd_en,
   input  logic [clipmix_pkg::CLIP_IDX_BITS-1:0]   rd_idx,
   output clipmix_pkg::clip_entry_type             rd_entry
);

   clipmix_pkg::clip_entry_type clip_mem [clipmix_pkg::CLIP_COUNT];
   logic [clipmix_pkg::CLIP_COUNT-1:0] valid_ff;
   clipmix_pkg::clip_entry_type rd_data_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         clip_mem[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= clip_mem[rd_idx];
      end
   end

   // An entry never written since reset reads as an empty clip.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

[rtl/core/clip_sample_mixer.sv]
// Four-voice PCM clip player. Sample bytes and clip entries are loaded with write
// transactions; a play transaction reads the clip table, then launches a voice; a tick
// transaction fetches the voices one per cycle, since the sample store has one read
// port, then drains the last read, then emits. The mixed result sits in an output
// register, so the next transaction is taken while it waits. The clip table is empty
// right after reset with no clearing pass; reading a sample store byte that was never
// written returns an arbitrary value.
module clip_sample_mixer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[7:0], mem_addr[23:8], sample_byte[31:24], clip_offset[47:32],
   // clip_length[64:48], clip_loop[65], zero fill[71:66]
   input  logic [71:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mixed_sample[7:0]
   output logic [7:0]  rsp_tdata
);

   localparam int VC = clipmix_pkg::VOICE_COUNT;
   localparam int VIB = clipmix_pkg::VOICE_IDX_BITS;
   localparam int LB = clipmix_pkg::LENGTH_BITS;
   localparam int ACCB = clipmix_pkg::ACC_BITS;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PLAY  = 5'b00010,
      ST_MIX   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [clipmix_pkg::CODE_BITS-1:0]           command;
   logic [15:0]                                 mem_addr;
   logic signed [clipmix_pkg::SAMPLE_BITS-1:0]  sample_byte;
   clipmix_pkg::clip_entry_type                 req_entry;
   clipmix_pkg::req_kind_type                   req_kind;
   logic                                        accept;
   logic                                        code_in_range;

   assign command           = req_tdata[7:0];
   assign mem_addr          = req_tdata[23:8];
   assign sample_byte       = req_tdata[31:24];
   assign req_entry.start   = req_tdata[47:32];
   assign req_entry.length  = req_tdata[64:48];
   assign req_entry.loop    = req_tdata[65];
   assign req_kind          = clipmix_pkg::req_kind_type'(req_tuser);
   assign accept            = req_tvalid && req_tready;
   assign code_in_range     = {1'b0, command} < 9'(clipmix_pkg::CLIP_COUNT);

   logic                                  active_ff [VC];
   logic                                  active_in [VC];
   logic                                  looping_ff [VC];
   logic                                  looping_in [VC];
   logic [clipmix_pkg::START_BITS-1:0]    start_ff [VC];
   logic [clipmix_pkg::START_BITS-1:0]    start_in [VC];
   logic [LB-1:0]                         length_ff [VC];
   logic [LB-1:0]                         length_in [VC];
   logic [LB-1:0]                         pos_ff [VC];
   logic [LB-1:0]                         pos_in [VC];

   logic [VIB-1:0]                        next_voice_ff, next_voice_in;
   logic [VIB-1:0]                        idx_ff, idx_in;
   logic                                  pend_ff, pend_in;
   logic                                  code_ok_ff, code_ok_in;
   logic signed [ACCB-1:0]                acc_ff, acc_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]                            rsp_data_ff, rsp_data_in;

   logic                                  sram_wr_en;
   logic [clipmix_pkg::SAMPLE_ADDR_BITS-1:0] sram_wr_addr;
   logic                                  sram_rd_en;
   logic [clipmix_pkg::SAMPLE_ADDR_BITS-1:0] sram_rd_addr;
   logic signed [clipmix_pkg::SAMPLE_BITS-1:0] sram_rd_data;
   logic                                  tbl_wr_en;
   logic                                  tbl_rd_en;
   clipmix_pkg::clip_entry_type           tbl_entry;

   logic [clipmix_pkg::ADDR_SUM_BITS-1:0] wr_addr_wide;
   logic [clipmix_pkg::ADDR_SUM_BITS-1:0] mix_addr_sum;
   logic [LB-1:0]                         pos_inc;
   logic                                  voice_live;
   logic [VIB:0]                          rr_wide;
   logic [VIB:0]                          rr_pick_wide;
   logic [VIB:0]                          rr_succ_wide;
   logic [VIB-1:0]                        rr_pick;
   logic [VIB-1:0]                        rr_next;
   logic [VIB-1:0]                        launch_voice;
   logic signed [ACCB-1:0]                sat_acc;

   assign wr_addr_wide = clipmix_pkg::ADDR_SUM_BITS'(mem_addr);
   assign sram_wr_addr = wr_addr_wide[clipmix_pkg::SAMPLE_ADDR_BITS-1:0];
   assign mix_addr_sum = clipmix_pkg::ADDR_SUM_BITS'(start_ff[idx_ff])
                       + clipmix_pkg::ADDR_SUM_BITS'(pos_ff[idx_ff]);
   assign sram_rd_addr = mix_addr_sum[clipmix_pkg::SAMPLE_ADDR_BITS-1:0];
   assign pos_inc      = pos_ff[idx_ff] + LB'(1);
   assign voice_live   = active_ff[idx_ff] && (length_ff[idx_ff] != '0);

   assign rr_wide      = {1'b0, next_voice_ff};
   assign rr_pick_wide = (next_voice_ff == '0 || rr_wide >= (VIB + 1)'(VC))
                       ? (VIB + 1)'(1) : rr_wide;
   assign rr_succ_wide = (rr_pick_wide + (VIB + 1)'(1) >= (VIB + 1)'(VC))
                       ? (VIB + 1)'(1) : rr_pick_wide + (VIB + 1)'(1);
   assign rr_pick      = rr_pick_wide[VIB-1:0];
   assign rr_next      = rr_succ_wide[VIB-1:0];
   assign launch_voice = tbl_entry.loop ? '0 : rr_pick;

   assign sat_acc = (acc_ff > clipmix_pkg::MIX_MAX_ACC) ? clipmix_pkg::MIX_MAX_ACC
                  : (acc_ff < clipmix_pkg::MIX_MIN_ACC) ? clipmix_pkg::MIX_MIN_ACC
                  : acc_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      next_voice_in = next_voice_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      code_ok_in    = code_ok_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      active_in     = active_ff;
      looping_in    = looping_ff;
      start_in      = start_ff;
      length_in     = length_ff;
      pos_in        = pos_ff;
      sram_wr_en    = 1'b0;
      sram_rd_en    = 1'b0;
      tbl_wr_en     = 1'b0;
      tbl_rd_en     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  clipmix_pkg::REQ_PLAY: begin
                     tbl_rd_en  = 1'b1;
                     code_ok_in = (command != clipmix_pkg::NO_CODE) && code_in_range;
                     state_in   = ST_PLAY;
                  end
                  clipmix_pkg::REQ_TICK: begin
                     idx_in   = '0;
                     acc_in   = '0;
                     state_in = ST_MIX;
                  end
                  clipmix_pkg::REQ_SAMPLE: begin
                     sram_wr_en = 1'b1;
                  end
                  clipmix_pkg::REQ_CLIP: begin
                     tbl_wr_en = code_in_range;
                  end
               endcase
            end
         end
         ST_PLAY: begin
            if (code_ok_ff && tbl_entry.length != '0) begin
               active_in[launch_voice]  = 1'b1;
               looping_in[launch_voice] = tbl_entry.loop;
               start_in[launch_voice]   = tbl_entry.start;
               length_in[launch_voice]  = tbl_entry.length;
               pos_in[launch_voice]     = '0;
               if (!tbl_entry.loop) begin
                  next_voice_in = rr_next;
               end
            end
            state_in = ST_IDLE;
         end
         ST_MIX: begin
            if (pend_ff) begin
               acc_in = acc_ff + ACCB'(sram_rd_data);
            end
            if (voice_live) begin
               sram_rd_en = 1'b1;
               pend_in    = 1'b1;
               if (pos_inc >= length_ff[idx_ff]) begin
                  pos_in[idx_ff] = '0;
                  if (!looping_ff[idx_ff]) begin
                     active_in[idx_ff] = 1'b0;
                  end
               end else begin
                  pos_in[idx_ff] = pos_inc;
               end
            end
            if (idx_ff == VIB'(VC - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + VIB'(1);
            end
         end
         ST_DRAIN: begin
            if (pend_ff) begin
               acc_in = acc_ff + ACCB'(sram_rd_data);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_acc[7:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_voice_ff <= VIB'(1);
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int v = 0; v < VC; v++) begin
            active_ff[v]  <= 1'b0;
            looping_ff[v] <= 1'b0;
            start_ff[v]   <= '0;
            length_ff[v]  <= '0;
            pos_ff[v]     <= '0;
         end
      end else begin
         state_ff      <= state_in;
         next_voice_ff <= next_voice_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         active_ff     <= active_in;
         looping_ff    <= looping_in;
         start_ff      <= start_in;
         length_ff     <= length_in;
         pos_ff        <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      code_ok_ff  <= code_ok_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   clipmix_sample_ram u_sample_ram (
      .clock   (clock),
      .wr_en   (sram_wr_en),
      .wr_addr (sram_wr_addr),
      .wr_data (sample_byte),
      .rd_en   (sram_rd_en),
      .rd_addr (sram_rd_addr),
      .rd_data (sram_rd_data)
   );

   clipmix_clip_table u_clip_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_idx   (command[clipmix_pkg::CLIP_IDX_BITS-1:0]),
      .wr_entry (req_entry),
      .rd_en    (tbl_rd_en),
      .rd_idx   (command[clipmix_pkg::CLIP_IDX_BITS-1:0]),
      .rd_entry (tbl_entry)
   );

   // A new result only ever comes out of the emit step.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the emit step");

   a_tick_starts_mix: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == clipmix_pkg::REQ_TICK) |=> (state_ff == ST_MIX && idx_ff == '0))
      else $error("tick did not start a mixing pass at voice zero");

   // Effect clips never land on the music voice.
   a_effect_voice_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLAY && !tbl_entry.loop) |-> (rr_pick != '0))
      else $error("effect clip assigned to the music voice");

endmodule
